[rtl/core/gamepad_report_to_joystick_state_defines.svh]
// Assertion macros for the gamepad report translator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef GAMEPAD_REPORT_TO_JOYSTICK_STATE_DEFINES_SVH
`define GAMEPAD_REPORT_TO_JOYSTICK_STATE_DEFINES_SVH

// checked only outside reset
`define GRJS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GRJS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/grjs_pkg.sv]
// Shared types, constants and the d-pad decode for the gamepad report translator.
// No dependencies.
package grjs_pkg;

  localparam int AXIS_MAG_W  = 16;  // |stick| up to 32768
  localparam int AXIS_SHIFT  = 15;  // divide by 2^15 or 2^15-1
  localparam int TRIG_MAG_W  = 8;
  localparam int TRIG_SHIFT  = 8;   // divide by 2^8-1

  localparam logic [7:0] TRIG_PRESS = 8'hC0;

  // configuration register indexes
  localparam logic [1:0] REG_AXIS_MIN = 2'd0;
  localparam logic [1:0] REG_AXIS_MAX = 2'd1;
  localparam logic [1:0] REG_FORMAT   = 2'd2;

  // format codes
  localparam logic [1:0] FMT_NONE     = 2'd0;
  localparam logic [1:0] FMT_BASIC    = 2'd1;
  localparam logic [1:0] FMT_EXTENDED = 2'd2;

  // d-pad codes, bit0 up, bit1 down, bit2 left, bit3 right
  localparam logic [3:0] DPAD_UP         = 4'b0001;
  localparam logic [3:0] DPAD_UP_RIGHT   = 4'b1001;
  localparam logic [3:0] DPAD_RIGHT      = 4'b1000;
  localparam logic [3:0] DPAD_RIGHT_DOWN = 4'b1010;
  localparam logic [3:0] DPAD_DOWN       = 4'b0010;
  localparam logic [3:0] DPAD_DOWN_LEFT  = 4'b0110;
  localparam logic [3:0] DPAD_LEFT       = 4'b0100;
  localparam logic [3:0] DPAD_LEFT_UP    = 4'b0101;

  localparam logic signed [15:0] HAT_CENTER = -16'sd1;

  typedef struct packed {
    logic [31:0]           coef_abs;
    logic                  neg;
    logic [AXIS_MAG_W-1:0] mag;
    logic                  pow2;     // divide by 2^15 exactly
  } axis_op_t;

  typedef struct packed {
    logic [31:0]           coef_abs;
    logic                  neg;
    logic [TRIG_MAG_W-1:0] mag;
  } trig_op_t;

  typedef struct packed {
    logic                 ok;
    logic signed [15:0]   hat;
    logic [11:0]          mask;
  } meta_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic logic signed [15:0] hat_of(input logic [3:0] dpad);
    logic signed [15:0] h;
    unique case (dpad)
      DPAD_UP:         h = 16'sd0;
      DPAD_UP_RIGHT:   h = 16'sd4500;
      DPAD_RIGHT:      h = 16'sd9000;
      DPAD_RIGHT_DOWN: h = 16'sd13500;
      DPAD_DOWN:       h = 16'sd18000;
      DPAD_DOWN_LEFT:  h = 16'sd22500;
      DPAD_LEFT:       h = 16'sd27000;
      DPAD_LEFT_UP:    h = 16'sd31500;
      default:         h = HAT_CENTER;
    endcase
    return h;
  endfunction

endpackage

[rtl/core/grjs_front.sv]
// Stage 1: unpacks a report beat, picks coefficient and magnitude per axis,
// decodes hat and button mask. Depends on grjs_pkg.
module grjs_front import grjs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [95:0]        rpt,        // input beat payload
  input  logic signed [31:0] range_min,
  input  logic signed [31:0] range_max,
  input  logic [1:0]         fmt,
  output axis_op_t           lx_op,
  output axis_op_t           ly_op,
  output axis_op_t           rx_op,
  output axis_op_t           ry_op,
  output trig_op_t           lt_op,
  output trig_op_t           rt_op,
  output meta_t              meta
);

  function automatic axis_op_t axis_op(input logic signed [15:0] v,
                                       input logic signed [31:0] lo,
                                       input logic signed [31:0] hi,
                                       input logic ok);
    axis_op_t o;
    logic signed [31:0] coef;
    coef       = v[15] ? lo : hi;
    o.coef_abs = coef[31] ? 32'(-coef) : 32'(coef);
    o.neg      = coef[31] & ok;
    o.mag      = v[15] ? AXIS_MAG_W'(-v) : AXIS_MAG_W'(v);
    o.pow2     = v[15];
    if (!ok) begin
      o.coef_abs = '0;   // no format: everything reads zero
    end
    return o;
  endfunction

  logic [15:0]        btn;
  logic [7:0]         lt, rt;
  logic signed [15:0] lx, ly, rx, ry;
  logic               ok;
  logic [31:0]        max_abs;
  axis_op_t           lx_nxt, ly_nxt, rx_nxt, ry_nxt;
  trig_op_t           lt_nxt, rt_nxt;
  meta_t              meta_nxt;

  assign btn = rpt[15:0];
  assign lt  = rpt[23:16];
  assign rt  = rpt[31:24];
  assign lx  = rpt[47:32];
  assign ly  = rpt[63:48];
  assign rx  = rpt[79:64];
  assign ry  = rpt[95:80];

  always_comb begin
    ok      = (fmt == FMT_BASIC) || (fmt == FMT_EXTENDED);
    max_abs = range_max[31] ? 32'(-range_max) : 32'(range_max);
    lx_nxt  = axis_op(lx, range_min, range_max, ok);
    ly_nxt  = axis_op(ly, range_max, range_min, ok);   // inverted
    rx_nxt  = axis_op(rx, range_min, range_max, ok);
    ry_nxt  = axis_op(ry, range_max, range_min, ok);   // inverted

    lt_nxt.coef_abs = ok ? max_abs : '0;
    lt_nxt.neg      = range_max[31] & ok;
    lt_nxt.mag      = lt;
    rt_nxt.coef_abs = ok ? max_abs : '0;
    rt_nxt.neg      = range_max[31] & ok;
    rt_nxt.mag      = rt;

    meta_nxt.ok   = ok;
    meta_nxt.hat  = ok ? hat_of(btn[3:0]) : 16'sd0;
    meta_nxt.mask = ok ? {rt >= TRIG_PRESS, lt >= TRIG_PRESS, btn[7:6], btn[4], btn[5],
                          btn[9:8], btn[15:12]} : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx_op <= lx_nxt;
      ly_op <= ly_nxt;
      rx_op <= rx_nxt;
      ry_op <= ry_nxt;
      lt_op <= lt_nxt;
      rt_op <= rt_nxt;
      meta  <= meta_nxt;
    end
  end

endmodule

[rtl/core/grjs_scale.sv]
// Stages 2-4 of one scaling lane: |coef|*mag, divide by 2^SHIFT or 2^SHIFT-1
// (series of shifts plus one correction), then sign. Depends on grjs_pkg.
module grjs_scale import grjs_pkg::*; #(
  parameter int MAG_W = AXIS_MAG_W,
  parameter int SHIFT = AXIS_SHIFT
) (
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [31:0]        coef_abs,
  input  logic               neg,
  input  logic [MAG_W-1:0]   mag,
  input  logic               pow2,
  output logic signed [31:0] result
);

  localparam int PROD_W = 32 + MAG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = PROD_W - SHIFT + 1;
  localparam int R_W    = PROD_W + 1;
  localparam int NTERMS = PROD_W / SHIFT + 1;
  localparam logic [R_W-1:0] DIV = R_W'((1 << SHIFT) - 1);

  // stage 2
  logic [PROD_W-1:0] prod_r;
  logic              neg2_r, pow2_2_r;
  // stage 3
  logic [Q_W-1:0]    q0_r, q0_nxt;
  logic [PROD_W-1:0] x3_r;
  logic              neg3_r, pow2_3_r;
  logic [SUM_W-1:0]  sum;
  // stage 4
  logic [R_W-1:0]    qd, rem;
  logic [Q_W-1:0]    q;
  logic [31:0]       mag32;
  logic signed [31:0] result_nxt;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r   <= PROD_W'(coef_abs) * PROD_W'(mag);
      neg2_r   <= neg;
      pow2_2_r <= pow2;
    end
  end

  // x/(2^S-1) ~ (x + x>>S + x>>2S + ...) >> S, low by at most one
  always_comb begin
    sum = '0;
    for (int k = 0; k < NTERMS; k++) begin
      sum = sum + SUM_W'(prod_r >> (k * SHIFT));
    end
    q0_nxt = pow2_2_r ? Q_W'(prod_r >> SHIFT) : Q_W'(sum >> SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      q0_r     <= q0_nxt;
      x3_r     <= prod_r;
      neg3_r   <= neg2_r;
      pow2_3_r <= pow2_2_r;
    end
  end

  always_comb begin
    qd         = (R_W'(q0_r) << SHIFT) - R_W'(q0_r);
    rem        = R_W'(x3_r) - qd;
    q          = q0_r + Q_W'(!pow2_3_r && (rem >= DIV));
    mag32      = 32'(q);
    result_nxt = neg3_r ? -$signed(mag32) : $signed(mag32);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      result <= result_nxt;
    end
  end

endmodule

[rtl/core/gamepad_report_to_joystick_state.sv]
// Top level of the gamepad report translator: config registers, pipeline
// flow control, six scaling lanes. Depends on grjs_pkg, grjs_front, grjs_scale.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  in_     | in  | tvalid / tready  | tdata 96b: one gamepad report
//  out_    | out | tvalid / tready  | tuser 1b result_valid, tdata 224b state
//  cfg_    | in  | we (no wait)     | addr 2b register index, wdata 32b
//
// One beat per cycle sustained while out_tready stays high; the path from input beat to output
// beat runs through the four register stages (decode, 32x16 multiply, reciprocal
// shift-sum, remainder correction with sign).
// Each stage holds its own valid bit and moves up when the stage after it is
// free, so bubbles close up and a stalled output still lets the front fill.
// rst_n: synchronous, active low, clears valid bits and config; write config only while empty.
`include "gamepad_report_to_joystick_state_defines.svh"

module gamepad_report_to_joystick_state import grjs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // pad_buttons[15:0], left_trigger[23:16], right_trigger[31:24],
  // left_stick_x[47:32], left_stick_y[63:48], right_stick_x[79:64],
  // right_stick_y[95:80]
  input  logic [95:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x_axis[31:0], y_axis[63:32], rx_axis[95:64], ry_axis[127:96],
  // slider_left[159:128], slider_right[191:160], hat_angle[207:192],
  // button_mask[219:208], zero pad[223:220]
  output logic [223:0] out_tdata,
  output logic [0:0]   out_tuser,  // result_valid[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic signed [31:0] range_min_r, range_max_r;
  logic [1:0]         fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= -32'sd65536;
      range_max_r <= 32'sd65536;
      fmt_r       <= FMT_NONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AXIS_MIN: range_min_r <= cfg_wdata;
        REG_AXIS_MAX: range_max_r <= cfg_wdata;
        REG_FORMAT:   fmt_r       <= cfg_wdata[1:0];
        default: ;    // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic      v1_r, v2_r, v3_r, v4_r;
  stage_en_t en;

  always_comb begin
    en.s4 = !v4_r || out_tready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_tready  = en.s1;
  assign out_tvalid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------- stage 1
  axis_op_t lx_op, ly_op, rx_op, ry_op;
  trig_op_t lt_op, rt_op;
  meta_t    meta1;

  grjs_front u_front (
    .clk       (clk),
    .en        (en.s1),
    .rpt       (in_tdata),
    .range_min (range_min_r),
    .range_max (range_max_r),
    .fmt       (fmt_r),
    .lx_op     (lx_op),
    .ly_op     (ly_op),
    .rx_op     (rx_op),
    .ry_op     (ry_op),
    .lt_op     (lt_op),
    .rt_op     (rt_op),
    .meta      (meta1)
  );

  // hat, mask and flag ride alongside the arithmetic
  meta_t meta2_r, meta3_r, meta4_r;

  always_ff @(posedge clk) begin
    if (en.s2) meta2_r <= meta1;
    if (en.s3) meta3_r <= meta2_r;
    if (en.s4) meta4_r <= meta3_r;
  end

  // ------------------------------------------------------- stages 2 to 4
  logic signed [31:0] x_axis, y_axis, rx_axis, ry_axis, slider_left, slider_right;

  grjs_scale #(.MAG_W(AXIS_MAG_W), .SHIFT(AXIS_SHIFT)) u_lx (
    .clk(clk), .en(en), .coef_abs(lx_op.coef_abs), .neg(lx_op.neg),
    .mag(lx_op.mag), .pow2(lx_op.pow2), .result(x_axis)
  );

  grjs_scale #(.MAG_W(AXIS_MAG_W), .SHIFT(AXIS_SHIFT)) u_ly (
    .clk(clk), .en(en), .coef_abs(ly_op.coef_abs), .neg(ly_op.neg),
    .mag(ly_op.mag), .pow2(ly_op.pow2), .result(y_axis)
  );

  grjs_scale #(.MAG_W(AXIS_MAG_W), .SHIFT(AXIS_SHIFT)) u_rx (
    .clk(clk), .en(en), .coef_abs(rx_op.coef_abs), .neg(rx_op.neg),
    .mag(rx_op.mag), .pow2(rx_op.pow2), .result(rx_axis)
  );

  grjs_scale #(.MAG_W(AXIS_MAG_W), .SHIFT(AXIS_SHIFT)) u_ry (
    .clk(clk), .en(en), .coef_abs(ry_op.coef_abs), .neg(ry_op.neg),
    .mag(ry_op.mag), .pow2(ry_op.pow2), .result(ry_axis)
  );

  // triggers always divide by 255
  grjs_scale #(.MAG_W(TRIG_MAG_W), .SHIFT(TRIG_SHIFT)) u_lt (
    .clk(clk), .en(en), .coef_abs(lt_op.coef_abs), .neg(lt_op.neg),
    .mag(lt_op.mag), .pow2(1'b0), .result(slider_left)
  );

  grjs_scale #(.MAG_W(TRIG_MAG_W), .SHIFT(TRIG_SHIFT)) u_rt (
    .clk(clk), .en(en), .coef_abs(rt_op.coef_abs), .neg(rt_op.neg),
    .mag(rt_op.mag), .pow2(1'b0), .result(slider_right)
  );

  // ---------------------------------------------------------------- output
  assign out_tdata = {4'b0000, meta4_r.mask, meta4_r.hat, slider_right, slider_left,
                      ry_axis, rx_axis, y_axis, x_axis};
  assign out_tuser = meta4_r.ok;

  // ------------------------------------------------------------ assertions
  `GRJS_ASSERT(a_zero_when_no_format, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "no-format beat carries nonzero data")
  `GRJS_ASSERT(a_backpressure_only_full, !in_tready |-> (v1_r && v2_r && v3_r && v4_r), "input stalled with a free stage")
  `GRJS_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule
